/* hdl/quat_nlerp_assert.svh */
// assertion macros for the quaternion nlerp checker
`ifndef QUAT_NLERP_ASSERT_SVH
`define QUAT_NLERP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define QNL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("quat_nlerp check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define QNL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("quat_nlerp check failed");

`endif

/* hdl/qnl_pkg.sv */
// lane count constant for the quaternion nlerp block
package qnl_pkg;

	// components per quaternion
	localparam int LANES = 4;

endpackage

/* hdl/quat_nlerp.sv */
// quaternion nlerp: pipelined normalised linear interpolation of two quaternions
//
// One item (two quaternions and a blend factor, all signed with COMP_WIDTH-2
// fraction bits) is taken at every clock edge where start is high; busy is
// always low because the pipeline never stalls. Each item gives exactly one
// result, shown for a single cycle with done high, in the order the items
// came in. The receiver cannot hold results off. The pipeline depth is set
// by the square root, which resolves one root bit per stage (COMP_WIDTH+1
// stages), and by the four lane dividers, which resolve one quotient bit per
// stage (COMP_WIDTH stages). A blend at or below zero passes the first
// quaternion through, a blend at or above one or two equal quaternions pass
// the second through; these items still go through every stage so order is
// kept. A blended sum of zero length gives zero components with zero_length
// set.
module quat_nlerp #(
	parameter int COMP_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COMP_WIDTH-1:0] from_x,
	input  logic signed [COMP_WIDTH-1:0] from_y,
	input  logic signed [COMP_WIDTH-1:0] from_z,
	input  logic signed [COMP_WIDTH-1:0] from_w,
	input  logic signed [COMP_WIDTH-1:0] to_x,
	input  logic signed [COMP_WIDTH-1:0] to_y,
	input  logic signed [COMP_WIDTH-1:0] to_z,
	input  logic signed [COMP_WIDTH-1:0] to_w,
	input  logic signed [COMP_WIDTH-1:0] blend,
	output logic                         done,
	output logic signed [COMP_WIDTH-1:0] out_x,
	output logic signed [COMP_WIDTH-1:0] out_y,
	output logic signed [COMP_WIDTH-1:0] out_z,
	output logic signed [COMP_WIDTH-1:0] out_w,
	output logic                         zero_length
);

	localparam int W  = COMP_WIDTH;
	localparam int F  = W - 2;          // fraction bits
	localparam int NL = qnl_pkg::LANES;
	localparam int PW = 2 * W;          // product width
	localparam int SW = 2 * W + 2;      // sum of squares width
	localparam int NB = W + 1;          // root bits, one per sqrt stage
	localparam int RW = W + 3;          // sqrt remainder width
	localparam int LW = W + 2;          // length width
	localparam int QB = W;              // quotient bits, one per divide stage
	localparam int DW = LW + 1;         // divider remainder width

	localparam logic signed [W-1:0] ONE  = {2'b01, {F{1'b0}}};
	localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [PW:0]         HALF = (PW+1)'(1) << (F - 1);

	// what travels beside the arithmetic: bypass decision, pass value,
	// zero-length flag and the rounded blended magnitudes with their signs
	typedef struct packed {
		logic                   byp;
		logic                   zero;
		logic [NL-1:0]          neg;
		logic [NL-1:0][W-1:0]   mag;
		logic [NL-1:0][W-1:0]   pass;
	} side_t;

	// no back-pressure anywhere, so an item is taken whenever start is high
	assign busy = 1'b0;

	logic signed [W-1:0] fin [NL];
	logic signed [W-1:0] gin [NL];

	assign fin[0] = from_x;
	assign fin[1] = from_y;
	assign fin[2] = from_z;
	assign fin[3] = from_w;
	assign gin[0] = to_x;
	assign gin[1] = to_y;
	assign gin[2] = to_z;
	assign gin[3] = to_w;

	// ---------------------------------------------------------------
	// stage 1: special cases and the dot-product terms
	// ---------------------------------------------------------------
	logic  t_le0;
	logic  t_ge1;
	logic  same;
	side_t side_in;

	always_comb begin
		same = 1'b1;
		for (int i = 0; i < NL; i++) begin
			if (fin[i] != gin[i]) begin
				same = 1'b0;
			end
		end
		t_le0 = blend[W-1] || (blend == '0);
		t_ge1 = !blend[W-1] && (blend >= ONE);
		side_in      = '0;
		side_in.byp  = t_le0 || t_ge1 || same;
		for (int i = 0; i < NL; i++) begin
			side_in.pass[i] = t_le0 ? fin[i] : gin[i];
		end
	end

	logic                vld_s1;
	logic signed [W-1:0] f_s1 [NL];
	logic signed [W-1:0] g_s1 [NL];
	logic signed [W-1:0] t_s1;
	logic signed [PW-1:0] prod_s1 [NL];
	side_t               side_s1;

	always_ff @(posedge clk) begin
		for (int i = 0; i < NL; i++) begin
			f_s1[i]    <= fin[i];
			g_s1[i]    <= gin[i];
			prod_s1[i] <= fin[i] * gin[i];
		end
		t_s1    <= blend;
		side_s1 <= side_in;
	end

	// ---------------------------------------------------------------
	// stage 2: dot product sign picks the weight of the second quaternion
	// ---------------------------------------------------------------
	logic signed [PW+1:0] dot;

	always_comb begin
		dot = (PW+2)'(prod_s1[0]) + (PW+2)'(prod_s1[1])
			+ (PW+2)'(prod_s1[2]) + (PW+2)'(prod_s1[3]);
	end

	logic                vld_s2;
	logic signed [W-1:0] f_s2 [NL];
	logic signed [W-1:0] g_s2 [NL];
	logic signed [W-1:0] w0_s2;
	logic signed [W-1:0] w1_s2;
	side_t               side_s2;

	always_ff @(posedge clk) begin
		f_s2    <= f_s1;
		g_s2    <= g_s1;
		w0_s2   <= ONE - t_s1;
		// a zero dot product counts as non-negative
		w1_s2   <= dot[PW+1] ? -t_s1 : t_s1;
		side_s2 <= side_s1;
	end

	// ---------------------------------------------------------------
	// stage 3: weighted components
	// ---------------------------------------------------------------
	logic                 vld_s3;
	logic signed [PW-1:0] pa_s3 [NL];
	logic signed [PW-1:0] pb_s3 [NL];
	side_t                side_s3;

	always_ff @(posedge clk) begin
		for (int i = 0; i < NL; i++) begin
			pa_s3[i] <= w0_s2 * f_s2[i];
			pb_s3[i] <= w1_s2 * g_s2[i];
		end
		side_s3 <= side_s2;
	end

	// ---------------------------------------------------------------
	// stage 4: blended sum, full precision
	// ---------------------------------------------------------------
	logic               vld_s4;
	logic signed [PW:0] v_s4 [NL];
	side_t              side_s4;

	always_ff @(posedge clk) begin
		for (int i = 0; i < NL; i++) begin
			v_s4[i] <= (PW+1)'(pa_s3[i]) + (PW+1)'(pb_s3[i]);
		end
		side_s4 <= side_s3;
	end

	// ---------------------------------------------------------------
	// stage 5: back to the component format, rounding half away from zero
	// ---------------------------------------------------------------
	logic [PW:0] av  [NL];
	logic [PW:0] rnd [NL];
	side_t       side_rnd;

	always_comb begin
		side_rnd = side_s4;
		for (int i = 0; i < NL; i++) begin
			av[i]  = v_s4[i][PW] ? (PW+1)'(-v_s4[i]) : (PW+1)'(v_s4[i]);
			rnd[i] = av[i] + HALF;
			side_rnd.neg[i] = v_s4[i][PW];
			side_rnd.mag[i] = rnd[i][F+W-1:F];
		end
	end

	logic  vld_s5;
	side_t side_s5;

	always_ff @(posedge clk) begin
		side_s5 <= side_rnd;
	end

	// ---------------------------------------------------------------
	// stage 6: squares
	// ---------------------------------------------------------------
	logic          vld_s6;
	logic [PW-1:0] sqr_s6 [NL];
	side_t         side_s6;

	always_ff @(posedge clk) begin
		for (int i = 0; i < NL; i++) begin
			sqr_s6[i] <= side_s5.mag[i] * side_s5.mag[i];
		end
		side_s6 <= side_s5;
	end

	// ---------------------------------------------------------------
	// stage 7: sum of squares and the zero-length test
	// ---------------------------------------------------------------
	logic [SW-1:0] ssum;
	side_t         side_sum;

	always_comb begin
		ssum = SW'(sqr_s6[0]) + SW'(sqr_s6[1]) + SW'(sqr_s6[2]) + SW'(sqr_s6[3]);
		side_sum      = side_s6;
		side_sum.zero = (ssum == '0);
	end

	logic          vld_s7;
	logic [SW-1:0] sum_s7;
	side_t         side_s7;

	always_ff @(posedge clk) begin
		sum_s7  <= ssum;
		side_s7 <= side_sum;
	end

	// ---------------------------------------------------------------
	// square root: restoring digit recurrence, one root bit per stage
	// entry 0 of each array is the stage 7 output
	// ---------------------------------------------------------------
	logic [NB:0]         sq_vld_s;
	logic [NB:0][RW-1:0] sq_rem_s;
	logic [NB:0][NB-1:0] sq_root_s;
	logic [NB:0][SW-1:0] sq_rest_s;
	side_t               sq_side_s [NB+1];

	assign sq_vld_s[0]  = vld_s7;
	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;
	assign sq_rest_s[0] = sum_s7;
	assign sq_side_s[0] = side_s7;

	for (genvar k = 0; k < NB; k++) begin : g_sqrt
		logic [RW+1:0] remx;
		logic [RW+1:0] trial;
		logic          ge;

		always_comb begin
			remx  = {sq_rem_s[k], sq_rest_s[k][SW-1 -: 2]};
			trial = (RW+2)'({sq_root_s[k], 2'b01});
			ge    = (remx >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[k+1] <= 1'b0;
			end else begin
				sq_vld_s[k+1] <= sq_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			sq_rem_s[k+1]  <= ge ? RW'(remx - trial) : RW'(remx);
			sq_root_s[k+1] <= {sq_root_s[k][NB-2:0], ge};
			sq_rest_s[k+1] <= sq_rest_s[k] << 2;
			sq_side_s[k+1] <= sq_side_s[k];
		end
	end

	// ---------------------------------------------------------------
	// round the root to nearest: add one when the remainder exceeds it
	// ---------------------------------------------------------------
	logic          vld_sr;
	logic [LW-1:0] len_sr;
	side_t         side_sr;

	always_ff @(posedge clk) begin
		len_sr  <= LW'(sq_root_s[NB])
			+ LW'(RW'(sq_rem_s[NB]) > RW'(sq_root_s[NB]));
		side_sr <= sq_side_s[NB];
	end

	// ---------------------------------------------------------------
	// divider set-up: numerator is mag * one plus half the length,
	// its top bits start the partial remainder
	// ---------------------------------------------------------------
	logic [PW-1:0] num [NL];

	always_comb begin
		for (int i = 0; i < NL; i++) begin
			num[i] = PW'({side_sr.mag[i], {F{1'b0}}}) + PW'(len_sr >> 1);
		end
	end

	logic [QB:0]                  dv_vld_s;
	logic [QB:0][NL-1:0][DW-1:0]  dv_rem_s;
	logic [QB:0][NL-1:0][QB-1:0]  dv_num_s;
	logic [QB:0][NL-1:0][QB-1:0]  dv_quo_s;
	logic [QB:0][LW-1:0]          dv_len_s;
	side_t                        dv_side_s [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else begin
			dv_vld_s[0] <= vld_sr;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NL; i++) begin
			dv_rem_s[0][i] <= DW'(num[i][PW-1:QB]);
			dv_num_s[0][i] <= num[i][QB-1:0];
			dv_quo_s[0][i] <= '0;
		end
		dv_len_s[0]  <= len_sr;
		dv_side_s[0] <= side_sr;
	end

	// one quotient bit per stage in each of the four lanes
	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [DW:0] rx [NL];
		logic [NL-1:0] ge;

		always_comb begin
			for (int i = 0; i < NL; i++) begin
				rx[i] = {dv_rem_s[k][i], dv_num_s[k][i][QB-1]};
				ge[i] = (rx[i] >= (DW+1)'(dv_len_s[k]));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < NL; i++) begin
				dv_rem_s[k+1][i] <= ge[i] ? DW'(rx[i] - (DW+1)'(dv_len_s[k])) : DW'(rx[i]);
				dv_num_s[k+1][i] <= dv_num_s[k][i] << 1;
				dv_quo_s[k+1][i] <= {dv_quo_s[k][i][QB-2:0], ge[i]};
			end
			dv_len_s[k+1]  <= dv_len_s[k];
			dv_side_s[k+1] <= dv_side_s[k];
		end
	end

	// ---------------------------------------------------------------
	// output: saturate, apply sign, then the pass-through and zero cases
	// ---------------------------------------------------------------
	logic signed [W-1:0] res [NL];
	logic [QB-1:0]       quo [NL];
	side_t               side_o;

	always_comb begin
		side_o = dv_side_s[QB];
		for (int i = 0; i < NL; i++) begin
			quo[i] = dv_quo_s[QB][i];
			if (side_o.neg[i]) begin
				res[i] = quo[i][W-1] ? CMIN : -W'(quo[i]);
			end else begin
				res[i] = quo[i][W-1] ? CMAX : W'(quo[i]);
			end
			if (side_o.byp) begin
				res[i] = side_o.pass[i];
			end else if (side_o.zero) begin
				res[i] = '0;
			end
		end
	end

	logic                done_q;
	logic signed [W-1:0] res_q [NL];
	logic                zero_q;

	always_ff @(posedge clk) begin
		res_q  <= res;
		zero_q <= side_o.zero && !side_o.byp;
	end

	// valid bits of the front stages, the root rounding stage and done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_sr <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_sr <= sq_vld_s[NB];
			done_q <= dv_vld_s[QB];
		end
	end

	assign done        = done_q;
	assign out_x       = res_q[0];
	assign out_y       = res_q[1];
	assign out_z       = res_q[2];
	assign out_w       = res_q[3];
	assign zero_length = zero_q;

endmodule

/* hdl/qnl_checker.sv */
// port-level checker for the quaternion nlerp block and its bind
`include "quat_nlerp_assert.svh"

module qnl_checker #(
	parameter int COMP_WIDTH = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic signed [COMP_WIDTH-1:0] from_x,
	input logic signed [COMP_WIDTH-1:0] blend,
	input logic signed [COMP_WIDTH-1:0] out_x,
	input logic signed [COMP_WIDTH-1:0] out_y,
	input logic signed [COMP_WIDTH-1:0] out_z,
	input logic signed [COMP_WIDTH-1:0] out_w,
	input logic                         zero_length
);

	localparam int LAT = 2 * COMP_WIDTH + 11;

	// the pipeline never pushes back
	`QNL_ASSERT_IMP(a_never_busy, 1'b1, !busy)

	// every result traces back to an item taken LAT earlier
	`QNL_ASSERT_IMP(a_done_has_item, done, $past(start, LAT))

	// a zero-length result carries zero components
	`QNL_ASSERT_IMP(a_zero_gives_zeros, done && zero_length,
		out_x == '0 && out_y == '0 && out_z == '0 && out_w == '0)

	// blend at or below zero passes the first quaternion's x through, zero_length low
	`QNL_ASSERT_IMP(a_low_blend_pass,
		done && ($past(blend[COMP_WIDTH-1], LAT) || $past(blend, LAT) == '0),
		out_x == $past(from_x, LAT) && !zero_length)

endmodule

bind quat_nlerp qnl_checker #(.COMP_WIDTH(COMP_WIDTH)) u_qnl_checker (.*);
